// ----- rtl/gcnf_pkg.sv -----
`default_nettype none

package gcnf_pkg;

    localparam int VAR_W         = 20;
    localparam int LIT_W         = 21;
    localparam int CMD_W         = 4;
    localparam int FANIN_W       = 4;
    localparam int NUM_IN        = 8;
    localparam int MAX_FANIN_DEF = 8;
    localparam int VAR_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH   = 2;
    localparam int STEP_W        = 4;

    localparam logic [CMD_W-1:0] CMD_AND    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_NAND   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_OR     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_NOR    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INV    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_BUF    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FANOUT = 4'd6;
    localparam logic [CMD_W-1:0] CMD_XOR    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_XNOR   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_DFF    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_INPUT  = 4'd10;

    typedef enum logic [2:0] {
        K_MULTI,
        K_INV,
        K_BUF,
        K_XOR,
        K_XNOR,
        K_ERR
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  in_pos;
        logic  z_pos;
    } t_gate_hdr;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIDE_X,
        ST_WIDE_Z,
        ST_WIDE_END,
        ST_BIN_X,
        ST_BIN_Z,
        ST_BIN_END,
        ST_SCRIPT,
        ST_ERR
    } t_back_st;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_Z,
        SRC_ZERO
    } t_src;

    typedef struct packed {
        t_src src;
        logic pos;
        logic fin;
    } t_script;

    // literal sequence of the fixed-shape gates, one entry per step
    function automatic t_script script_step(t_kind kind, logic [STEP_W-1:0] step);
        t_script    s;
        logic [1:0] c;
        logic [1:0] p;
        logic [3:0] pa;
        logic [3:0] pb;
        logic [3:0] pz;
        s  = '{src: SRC_ZERO, pos: 1'b0, fin: 1'b1};
        c  = step[3:2];
        p  = step[1:0];
        pa = (kind == K_XOR) ? 4'b0110 : 4'b1001;
        pb = (kind == K_XOR) ? 4'b1010 : 4'b0101;
        pz = (kind == K_XOR) ? 4'b1100 : 4'b0011;
        unique case (kind)
            K_INV, K_BUF: begin
                unique case (step)
                    4'd0:    s = '{src: SRC_A, pos: (kind == K_INV), fin: 1'b0};
                    4'd1:    s = '{src: SRC_Z, pos: 1'b1, fin: 1'b0};
                    4'd2:    s = '{src: SRC_ZERO, pos: 1'b0, fin: 1'b0};
                    4'd3:    s = '{src: SRC_A, pos: (kind == K_BUF), fin: 1'b0};
                    4'd4:    s = '{src: SRC_Z, pos: 1'b0, fin: 1'b0};
                    default: s = '{src: SRC_ZERO, pos: 1'b0, fin: 1'b1};
                endcase
            end
            K_XOR, K_XNOR: begin
                unique case (p)
                    2'd0:    s = '{src: SRC_A, pos: pa[c], fin: 1'b0};
                    2'd1:    s = '{src: SRC_B, pos: pb[c], fin: 1'b0};
                    2'd2:    s = '{src: SRC_Z, pos: pz[c], fin: 1'b0};
                    default: s = '{src: SRC_ZERO, pos: 1'b0, fin: (c == 2'd3)};
                endcase
            end
            default: s = '{src: SRC_ZERO, pos: 1'b0, fin: 1'b1};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gcnf_front.sv -----
`default_nettype none

module gcnf_front #(
    parameter int MAX_FANIN = gcnf_pkg::MAX_FANIN_DEF,
    parameter int VW        = gcnf_pkg::VAR_BITS_DEF,
    parameter int NW        = $clog2(MAX_FANIN + 1)
) (
    input  wire logic                                               i_clk,
    input  wire logic                                               i_rst_n,
    input  wire logic                                               push,
    output logic                                                    full,
    input  wire logic [gcnf_pkg::CMD_W-1:0]                         i_cmd,
    input  wire logic [gcnf_pkg::VAR_W-1:0]                         i_out_var,
    input  wire logic [gcnf_pkg::FANIN_W-1:0]                       i_fan_in,
    input  wire logic [gcnf_pkg::NUM_IN-1:0][gcnf_pkg::VAR_W-1:0]   i_in_vars,
    output logic                                                    o_valid,
    input  wire logic                                               i_q_ready,
    output gcnf_pkg::t_gate_hdr                                     o_hdr,
    output logic [NW-1:0]                                           o_n,
    output logic [VW-1:0]                                           o_z,
    output logic [MAX_FANIN-1:0][VW-1:0]                            o_vars
);

    localparam logic [gcnf_pkg::FANIN_W-1:0] FANIN_LIM = gcnf_pkg::FANIN_W'(MAX_FANIN);

    logic                                r_valid;
    gcnf_pkg::t_gate_hdr                 r_hdr;
    logic [NW-1:0]                       r_n;
    logic [VW-1:0]                       r_z;
    logic [MAX_FANIN-1:0][VW-1:0]        r_vars;

    gcnf_pkg::t_gate_hdr                 hdr;
    logic                                no_clause;
    logic                                in_ready;
    logic [NW-1:0]                       n_sat;

    always_comb begin
        hdr       = '{kind: gcnf_pkg::K_ERR, in_pos: 1'b0, z_pos: 1'b0};
        no_clause = 1'b0;
        unique case (i_cmd)
            gcnf_pkg::CMD_AND:    hdr = '{kind: gcnf_pkg::K_MULTI, in_pos: 1'b0, z_pos: 1'b1};
            gcnf_pkg::CMD_NAND:   hdr = '{kind: gcnf_pkg::K_MULTI, in_pos: 1'b0, z_pos: 1'b0};
            gcnf_pkg::CMD_OR:     hdr = '{kind: gcnf_pkg::K_MULTI, in_pos: 1'b1, z_pos: 1'b0};
            gcnf_pkg::CMD_NOR:    hdr = '{kind: gcnf_pkg::K_MULTI, in_pos: 1'b1, z_pos: 1'b1};
            gcnf_pkg::CMD_INV:    hdr.kind = gcnf_pkg::K_INV;
            gcnf_pkg::CMD_BUF,
            gcnf_pkg::CMD_FANOUT: hdr.kind = gcnf_pkg::K_BUF;
            gcnf_pkg::CMD_XOR:    hdr.kind = gcnf_pkg::K_XOR;
            gcnf_pkg::CMD_XNOR:   hdr.kind = gcnf_pkg::K_XNOR;
            gcnf_pkg::CMD_DFF,
            gcnf_pkg::CMD_INPUT:  no_clause = 1'b1;
            default:              hdr.kind = gcnf_pkg::K_ERR;
        endcase
    end

    assign n_sat    = (i_fan_in > FANIN_LIM) ? NW'(FANIN_LIM) : NW'(i_fan_in);
    assign in_ready = !r_valid || i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            // flip-flop and primary-input items are dropped here
            r_valid <= push && !no_clause;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && push) begin
            r_hdr <= hdr;
            r_n   <= n_sat;
            r_z   <= i_out_var[VW-1:0];
            for (int k = 0; k < MAX_FANIN; k++) begin
                r_vars[k] <= i_in_vars[k][VW-1:0];
            end
        end
    end

    assign full    = !in_ready;
    assign o_valid = r_valid;
    assign o_hdr   = r_hdr;
    assign o_n     = r_n;
    assign o_z     = r_z;
    assign o_vars  = r_vars;

endmodule

`default_nettype wire

// ----- rtl/gcnf_queue.sv -----
`default_nettype none

module gcnf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gcnf_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    output logic                  o_wr_ready,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_pop,
    output logic [WIDTH-1:0]      o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [AW-1:0]               r_wr_ptr;
    logic [AW-1:0]               r_rd_ptr;
    logic [CW-1:0]               r_count;
    logic                        do_wr;
    logic                        do_rd;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign do_wr      = i_wr_valid && o_wr_ready;
    assign do_rd      = i_rd_pop && o_rd_valid;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gcnf_back.sv -----
`default_nettype none

module gcnf_back #(
    parameter int MAX_FANIN = gcnf_pkg::MAX_FANIN_DEF,
    parameter int VW        = gcnf_pkg::VAR_BITS_DEF,
    parameter int NW        = $clog2(MAX_FANIN + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_q_valid,
    output logic                                      o_q_pop,
    input  wire gcnf_pkg::t_gate_hdr                  i_hdr,
    input  wire logic [NW-1:0]                        i_n,
    input  wire logic [VW-1:0]                        i_z,
    input  wire logic [MAX_FANIN-1:0][VW-1:0]         i_vars,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [gcnf_pkg::LIT_W-1:0]         o_literal,
    output logic                                      o_last,
    output logic                                      o_status
);

    localparam int IW    = $clog2(MAX_FANIN);
    localparam int LIT_W = gcnf_pkg::LIT_W;

    gcnf_pkg::t_back_st                r_st;
    gcnf_pkg::t_back_st                n_st;
    gcnf_pkg::t_gate_hdr               r_hdr;
    logic [NW-1:0]                     r_n;
    logic [VW-1:0]                     r_z;
    logic [MAX_FANIN-1:0][VW-1:0]      r_vars;
    logic [IW-1:0]                     r_idx;
    logic [IW-1:0]                     n_idx;
    logic [gcnf_pkg::STEP_W-1:0]       r_step;
    logic [gcnf_pkg::STEP_W-1:0]       n_step;

    logic                              r_ov;
    logic signed [LIT_W-1:0]           r_lit;
    logic                              r_last;
    logic                              r_status;

    gcnf_pkg::t_script                 sc;
    logic [VW-1:0]                     sel_var;
    logic                              sel_pos;
    logic                              sel_zero;
    logic                              fin;
    logic                              err;
    logic                              idx_last;
    logic                              emit;
    logic                              load;
    logic [LIT_W-1:0]                  lit_mag;
    logic [LIT_W-1:0]                  lit_val;
    gcnf_pkg::t_back_st                init_st;

    assign idx_last = (NW'(r_idx) == r_n - NW'(1));
    assign sc       = gcnf_pkg::script_step(r_hdr.kind, r_step);

    always_comb begin
        sel_var  = r_z;
        sel_pos  = 1'b0;
        sel_zero = 1'b0;
        fin      = 1'b0;
        err      = 1'b0;
        n_st     = r_st;
        n_idx    = r_idx;
        n_step   = r_step + gcnf_pkg::STEP_W'(1);
        unique case (r_st)
            gcnf_pkg::ST_IDLE: begin
                sel_zero = 1'b1;
            end
            gcnf_pkg::ST_WIDE_X: begin
                sel_var = r_vars[r_idx];
                sel_pos = r_hdr.in_pos;
                if (idx_last) begin
                    n_st = gcnf_pkg::ST_WIDE_Z;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            gcnf_pkg::ST_WIDE_Z: begin
                sel_pos = r_hdr.z_pos;
                n_st    = gcnf_pkg::ST_WIDE_END;
            end
            gcnf_pkg::ST_WIDE_END: begin
                sel_zero = 1'b1;
                // an empty gate ends after its one-literal clause
                fin      = (r_n == '0);
                n_st     = gcnf_pkg::ST_BIN_X;
                n_idx    = '0;
            end
            gcnf_pkg::ST_BIN_X: begin
                sel_var = r_vars[r_idx];
                sel_pos = !r_hdr.in_pos;
                n_st    = gcnf_pkg::ST_BIN_Z;
            end
            gcnf_pkg::ST_BIN_Z: begin
                sel_pos = !r_hdr.z_pos;
                n_st    = gcnf_pkg::ST_BIN_END;
            end
            gcnf_pkg::ST_BIN_END: begin
                sel_zero = 1'b1;
                fin      = idx_last;
                n_st     = gcnf_pkg::ST_BIN_X;
                n_idx    = r_idx + IW'(1);
            end
            gcnf_pkg::ST_SCRIPT: begin
                unique case (sc.src)
                    gcnf_pkg::SRC_A: sel_var  = r_vars[0];
                    gcnf_pkg::SRC_B: sel_var  = r_vars[1];
                    gcnf_pkg::SRC_Z: sel_var  = r_z;
                    default:         sel_zero = 1'b1;
                endcase
                sel_pos = sc.pos;
                fin     = sc.fin;
            end
            gcnf_pkg::ST_ERR: begin
                sel_zero = 1'b1;
                err      = 1'b1;
                fin      = 1'b1;
            end
            default: begin
                sel_zero = 1'b1;
                fin      = 1'b1;
            end
        endcase
    end

    // one literal per cycle while the output register is free or being drained
    assign emit    = (r_st != gcnf_pkg::ST_IDLE) && (!r_ov || pop);
    assign load    = i_q_valid && ((r_st == gcnf_pkg::ST_IDLE) || (emit && fin));
    assign o_q_pop = load;

    always_comb begin
        unique case (i_hdr.kind)
            gcnf_pkg::K_MULTI: init_st = (i_n == '0) ? gcnf_pkg::ST_WIDE_Z
                                                     : gcnf_pkg::ST_WIDE_X;
            gcnf_pkg::K_INV,
            gcnf_pkg::K_BUF,
            gcnf_pkg::K_XOR,
            gcnf_pkg::K_XNOR:  init_st = gcnf_pkg::ST_SCRIPT;
            gcnf_pkg::K_ERR:   init_st = gcnf_pkg::ST_ERR;
            default:           init_st = gcnf_pkg::ST_ERR;
        endcase
    end

    assign lit_mag = LIT_W'(sel_var);
    assign lit_val = sel_zero ? '0 : (sel_pos ? lit_mag : ({LIT_W{1'b0}} - lit_mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= gcnf_pkg::ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (load) begin
                r_st <= init_st;
            end else if (emit) begin
                r_st <= fin ? gcnf_pkg::ST_IDLE : n_st;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hdr  <= i_hdr;
            r_n    <= i_n;
            r_z    <= i_z;
            r_vars <= i_vars;
            r_idx  <= '0;
            r_step <= '0;
        end else if (emit) begin
            r_idx  <= n_idx;
            r_step <= n_step;
        end
        if (emit) begin
            r_lit    <= lit_val;
            r_last   <= fin;
            r_status <= err;
        end
    end

    assign empty     = !r_ov;
    assign o_literal = r_lit;
    assign o_last    = r_last;
    assign o_status  = r_status;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_status |-> r_last)
        else $error("error result without last");

    a_err_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_status |-> (r_lit == '0))
        else $error("error result with nonzero literal");

    a_idle_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && fin && !i_q_valid |=> (r_st == gcnf_pkg::ST_IDLE))
        else $error("sequencer still busy after final literal");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == gcnf_pkg::ST_WIDE_X) || (r_st == gcnf_pkg::ST_BIN_X) |->
            (NW'(r_idx) < r_n))
        else $error("input index beyond fan-in");

endmodule

`default_nettype wire

// ----- rtl/gate_cnf_clause_emitter_core.sv -----
// Tseitin clause emitter: one netlist gate in, its CNF clauses out as a
// literal stream, each clause closed by a zero literal, o_last on the
// final literal of a gate, o_status set on the single result of an
// unsupported gate type. Flip-flop and primary-input items give nothing.
// Input side: a gate is taken on a clock edge with push high and full low.
// Result side: the oldest literal sits on o_literal/o_last/o_status while
// empty is low and is taken on an edge with pop high.
// When the block is empty, the first literal of a gate passes the front
// register (loaded at the transfer edge), then the gate queue, the
// sequencer and the output register.
// Throughput: the sequencer emits one literal per cycle while the output
// register is free or being drained; a gate gives 4*fan_in+2 literals
// for AND/NAND/OR/NOR (34 at fan-in 8), 6 for INV/BUF/fanout, 16 for
// XOR/XNOR, 1 for an unsupported type; back-to-back gates follow with no
// gap. The front keeps taking gates until the queue and its own register
// are full. A stalled receiver holds the output register and the
// sequencer; full rises once the queue backs up. Reset empties all
// stages; full and empty are valid in the first cycle after it.
`default_nettype none

module gate_cnf_clause_emitter_core #(
    parameter int MAX_FANIN = gcnf_pkg::MAX_FANIN_DEF,
    parameter int VAR_BITS  = gcnf_pkg::VAR_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [gcnf_pkg::CMD_W-1:0]           i_cmd,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_out_var,
    input  wire logic [gcnf_pkg::FANIN_W-1:0]         i_fan_in,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_0,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_1,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_2,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_3,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_4,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_5,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_6,
    input  wire logic [gcnf_pkg::VAR_W-1:0]           i_in_var_7,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [gcnf_pkg::LIT_W-1:0]         o_literal,
    output logic                                      o_last,
    output logic                                      o_status
);

    // variable bits above the port width cannot occur
    localparam int VW = (VAR_BITS < gcnf_pkg::VAR_W) ? VAR_BITS : gcnf_pkg::VAR_W;
    localparam int NW = $clog2(MAX_FANIN + 1);
    localparam int DW = $bits(gcnf_pkg::t_gate_hdr) + NW + VW * (MAX_FANIN + 1);

    logic [gcnf_pkg::NUM_IN-1:0][gcnf_pkg::VAR_W-1:0] in_vars;

    logic                              f_valid;
    logic                              q_wr_ready;
    gcnf_pkg::t_gate_hdr               f_hdr;
    logic [NW-1:0]                     f_n;
    logic [VW-1:0]                     f_z;
    logic [MAX_FANIN-1:0][VW-1:0]      f_vars;

    logic                              q_rd_valid;
    logic                              q_pop;
    logic [DW-1:0]                     q_rd_data;
    gcnf_pkg::t_gate_hdr               b_hdr;
    logic [NW-1:0]                     b_n;
    logic [VW-1:0]                     b_z;
    logic [MAX_FANIN-1:0][VW-1:0]      b_vars;

    assign in_vars[0] = i_in_var_0;
    assign in_vars[1] = i_in_var_1;
    assign in_vars[2] = i_in_var_2;
    assign in_vars[3] = i_in_var_3;
    assign in_vars[4] = i_in_var_4;
    assign in_vars[5] = i_in_var_5;
    assign in_vars[6] = i_in_var_6;
    assign in_vars[7] = i_in_var_7;

    gcnf_front #(
        .MAX_FANIN (MAX_FANIN),
        .VW        (VW),
        .NW        (NW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_cmd     (i_cmd),
        .i_out_var (i_out_var),
        .i_fan_in  (i_fan_in),
        .i_in_vars (in_vars),
        .o_valid   (f_valid),
        .i_q_ready (q_wr_ready),
        .o_hdr     (f_hdr),
        .o_n       (f_n),
        .o_z       (f_z),
        .o_vars    (f_vars)
    );

    gcnf_queue #(
        .WIDTH (DW),
        .DEPTH (gcnf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (q_wr_ready),
        .i_wr_data  ({f_hdr, f_n, f_z, f_vars}),
        .o_rd_valid (q_rd_valid),
        .i_rd_pop   (q_pop),
        .o_rd_data  (q_rd_data)
    );

    assign {b_hdr, b_n, b_z, b_vars} = q_rd_data;

    gcnf_back #(
        .MAX_FANIN (MAX_FANIN),
        .VW        (VW),
        .NW        (NW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_rd_valid),
        .o_q_pop   (q_pop),
        .i_hdr     (b_hdr),
        .i_n       (b_n),
        .i_z       (b_z),
        .i_vars    (b_vars),
        .empty     (empty),
        .pop       (pop),
        .o_literal (o_literal),
        .o_last    (o_last),
        .o_status  (o_status)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;

    import gcnf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PER_PHASE = 135;
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ERROR
    } chk_t;

    typedef struct packed {
        logic [CMD_W-1:0]              cmd;
        logic [VAR_W-1:0]              out_var;
        logic [FANIN_W-1:0]            fan_in;
        logic [NUM_IN-1:0][VAR_W-1:0]  in_var;
    } gate_t;

    typedef struct {
        gate_t g;
        chk_t  chk;
    } dir_row_t;

    typedef struct packed {
        logic signed [LIT_W-1:0] literal;
        logic                    last;
        logic                    status;
    } lit_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic [CMD_W-1:0]           i_cmd;
    logic [VAR_W-1:0]           i_out_var;
    logic [FANIN_W-1:0]         i_fan_in;
    logic [VAR_W-1:0]           i_in_var_0;
    logic [VAR_W-1:0]           i_in_var_1;
    logic [VAR_W-1:0]           i_in_var_2;
    logic [VAR_W-1:0]           i_in_var_3;
    logic [VAR_W-1:0]           i_in_var_4;
    logic [VAR_W-1:0]           i_in_var_5;
    logic [VAR_W-1:0]           i_in_var_6;
    logic [VAR_W-1:0]           i_in_var_7;
    logic                       empty;
    logic                       pop;
    logic signed [LIT_W-1:0]    o_literal;
    logic                       o_last;
    logic                       o_status;

    lit_t clause_lits[$];
    int   failures;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   hold_off_req;
    bit   rx_enable;

    gate_cnf_clause_emitter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (i_cmd),
        .i_out_var  (i_out_var),
        .i_fan_in   (i_fan_in),
        .i_in_var_0 (i_in_var_0),
        .i_in_var_1 (i_in_var_1),
        .i_in_var_2 (i_in_var_2),
        .i_in_var_3 (i_in_var_3),
        .i_in_var_4 (i_in_var_4),
        .i_in_var_5 (i_in_var_5),
        .i_in_var_6 (i_in_var_6),
        .i_in_var_7 (i_in_var_7),
        .empty      (empty),
        .pop        (pop),
        .o_literal  (o_literal),
        .o_last     (o_last),
        .o_status   (o_status)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic signed [LIT_W-1:0] lit_of(logic [VAR_W-1:0] v, bit pos);
        logic signed [LIT_W-1:0] l;
        l = $signed({1'b0, v});
        return pos ? l : -l;
    endfunction

    function automatic void emit(logic signed [LIT_W-1:0] l);
        clause_lits.push_back('{literal: l, last: 1'b0, status: 1'b0});
    endfunction

    // appends the clause stream of one gate to the expected literals
    function automatic void tseitin_encode(gate_t g);
        int          n;
        int          start;
        bit          in_pos;
        bit          z_pos;
        bit          flip;
        logic [3:0]  pa;
        logic [3:0]  pb;
        logic [3:0]  pz;
        start = clause_lits.size();
        n = (g.fan_in > MAX_FANIN_DEF) ? MAX_FANIN_DEF : int'(g.fan_in);
        // xor clause polarities; xnor is the complement
        pa = 4'b0110;
        pb = 4'b1010;
        pz = 4'b1100;
        case (g.cmd)
            CMD_AND, CMD_NAND, CMD_OR, CMD_NOR: begin
                in_pos = (g.cmd == CMD_OR) || (g.cmd == CMD_NOR);
                z_pos  = (g.cmd == CMD_AND) || (g.cmd == CMD_NOR);
                for (int i = 0; i < n; i++)
                    emit(lit_of(g.in_var[i], in_pos));
                emit(lit_of(g.out_var, z_pos));
                emit('0);
                for (int i = 0; i < n; i++) begin
                    emit(lit_of(g.in_var[i], !in_pos));
                    emit(lit_of(g.out_var, !z_pos));
                    emit('0);
                end
            end
            CMD_INV, CMD_BUF, CMD_FANOUT: begin
                for (int c = 0; c < 2; c++) begin
                    emit(lit_of(g.in_var[0], (g.cmd == CMD_INV) ^ c[0]));
                    emit(lit_of(g.out_var, !c[0]));
                    emit('0);
                end
            end
            CMD_XOR, CMD_XNOR: begin
                flip = (g.cmd == CMD_XNOR);
                for (int c = 0; c < 4; c++) begin
                    emit(lit_of(g.in_var[0], pa[c] ^ flip));
                    emit(lit_of(g.in_var[1], pb[c] ^ flip));
                    emit(lit_of(g.out_var, pz[c] ^ flip));
                    emit('0);
                end
            end
            CMD_DFF, CMD_INPUT: begin
            end
            default: clause_lits.push_back('{literal: '0, last: 1'b0, status: 1'b1});
        endcase
        if (clause_lits.size() > start)
            clause_lits[$].last = 1'b1;
    endfunction

    function automatic logic [VAR_W-1:0] random_var();
        int t;
        t = $urandom_range(19);
        if (t == 0)
            return '0;
        else if (t == 1)
            return VAR_MAX;
        else if (t == 2)
            return VAR_W'($urandom_range(1, 15));
        return VAR_W'($urandom_range(1, int'(VAR_MAX)));
    endfunction

    function automatic gate_t random_gate();
        gate_t g;
        int    r;
        int    s;
        r = $urandom_range(99);
        s = $urandom_range(99);
        if (r < 55)
            g.cmd = CMD_W'($urandom_range(CMD_AND, CMD_NOR));
        else if (r < 80)
            g.cmd = CMD_W'($urandom_range(CMD_INV, CMD_XNOR));
        else if (r < 90)
            g.cmd = CMD_W'($urandom_range(CMD_DFF, CMD_INPUT));
        else
            g.cmd = CMD_W'($urandom_range(CMD_INPUT + 1, 2**CMD_W - 1));
        if (s < 80)
            g.fan_in = FANIN_W'($urandom_range(1, MAX_FANIN_DEF));
        else if (s < 88)
            g.fan_in = '0;
        else
            g.fan_in = FANIN_W'($urandom_range(MAX_FANIN_DEF + 1, 2**FANIN_W - 1));
        g.out_var = random_var();
        for (int i = 0; i < NUM_IN; i++)
            g.in_var[i] = random_var();
        return g;
    endfunction

    function automatic dir_row_t row(logic [CMD_W-1:0] cmd, logic [VAR_W-1:0] z,
                                     logic [FANIN_W-1:0] n, logic [VAR_W-1:0] base,
                                     logic [VAR_W-1:0] stride, chk_t chk);
        dir_row_t r;
        r.g.cmd     = cmd;
        r.g.out_var = z;
        r.g.fan_in  = n;
        for (int i = 0; i < NUM_IN; i++)
            r.g.in_var[i] = base + VAR_W'(i) * stride;
        r.chk = chk;
        return r;
    endfunction

    task automatic drive_gate(gate_t g);
        i_cmd      = g.cmd;
        i_out_var  = g.out_var;
        i_fan_in   = g.fan_in;
        i_in_var_0 = g.in_var[0];
        i_in_var_1 = g.in_var[1];
        i_in_var_2 = g.in_var[2];
        i_in_var_3 = g.in_var[3];
        i_in_var_4 = g.in_var[4];
        i_in_var_5 = g.in_var[5];
        i_in_var_6 = g.in_var[6];
        i_in_var_7 = g.in_var[7];
    endtask

    task automatic send_gate(gate_t g, chk_t chk);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push = 1'b0;
            drive_gate(random_gate());
            @(negedge i_clk);
        end
        drive_gate(g);
        push = 1'b1;
        do
            @(posedge i_clk);
        while (full);
        case (chk)
            CHK_MODEL: tseitin_encode(g);
            CHK_ERROR: clause_lits.push_back('{literal: '0, last: 1'b1, status: 1'b1});
            default: ;
        endcase
    endtask

    function automatic void check_literal();
        lit_t exp_lit;
        if (clause_lits.size() == 0) begin
            $error("literal %0d with no transfer expected", o_literal);
            failures++;
        end else begin
            exp_lit = clause_lits.pop_front();
            if (o_literal !== exp_lit.literal) begin
                $error("literal: expected %0d, got %0d", exp_lit.literal, o_literal);
                failures++;
            end
            if (o_last !== exp_lit.last) begin
                $error("last: expected %0b, got %0b", exp_lit.last, o_last);
                failures++;
            end
            if (o_status !== exp_lit.status) begin
                $error("status: expected %0b, got %0b", exp_lit.status, o_status);
                failures++;
            end
        end
    endfunction

    // result side; one long hold-off lets the block back up into full
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        wait (rx_enable);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                pop = 1'b0;
                hold_left--;
            end else begin
                pop = ($urandom_range(99) >= rx_idle_pct);
            end
            @(posedge i_clk);
            if (pop && !empty)
                check_literal();
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        failures     = 0;
        hold_off_req = 1'b0;
        rx_enable    = 1'b0;
        tx_idle_pct  = 21;
        rx_idle_pct  = 86;
        push         = 1'b0;
        drive_gate('0);
        i_rst_n      = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n   = 1'b1;
        rx_enable = 1'b1;

        rows.push_back(row(CMD_AND,    20'd1,     4'd1,  20'd2,     20'd1,     CHK_MODEL));
        // widest gate, every variable at its maximum
        rows.push_back(row(CMD_NAND,   VAR_MAX,   4'd8,  VAR_MAX,   20'd0,     CHK_MODEL));
        // empty gates: wide clause holds only the output
        rows.push_back(row(CMD_OR,     20'd77,    4'd0,  20'd5,     20'd3,     CHK_MODEL));
        rows.push_back(row(CMD_NAND,   20'd3,     4'd0,  20'd9,     20'd1,     CHK_MODEL));
        rows.push_back(row(CMD_NOR,    20'd9,     4'd0,  20'd4,     20'd2,     CHK_MODEL));
        rows.push_back(row(CMD_AND,    20'd11,    4'd0,  20'd6,     20'd2,     CHK_MODEL));
        // fan-in beyond the limit saturates
        rows.push_back(row(CMD_NOR,    20'd100,   4'd15, 20'h80000, 20'h11111, CHK_MODEL));
        rows.push_back(row(CMD_AND,    20'hAAAAA, 4'd9,  20'h55555, 20'h01010, CHK_MODEL));
        rows.push_back(row(CMD_INV,    VAR_MAX,   4'd0,  20'd1,     20'd0,     CHK_MODEL));
        rows.push_back(row(CMD_BUF,    20'd1,     4'd3,  VAR_MAX,   20'd1,     CHK_MODEL));
        rows.push_back(row(CMD_FANOUT, 20'h12345, 4'd15, 20'h6789A, 20'd7,     CHK_MODEL));
        rows.push_back(row(CMD_XOR,    VAR_MAX,   4'd0,  20'd1,     20'hFFFFE, CHK_MODEL));
        rows.push_back(row(CMD_XNOR,   20'd1,     4'd2,  VAR_MAX,   20'h80000, CHK_MODEL));
        // variable number zero goes out as a zero literal
        rows.push_back(row(CMD_XOR,    20'd0,     4'd2,  20'd0,     20'd4,     CHK_MODEL));
        rows.push_back(row(CMD_OR,     20'd0,     4'd4,  20'd0,     20'd0,     CHK_MODEL));
        rows.push_back(row(CMD_DFF,    20'd5,     4'd2,  20'd6,     20'd1,     CHK_NONE));
        rows.push_back(row(CMD_INPUT,  VAR_MAX,   4'd8,  VAR_MAX,   20'd0,     CHK_NONE));
        for (int c = CMD_INPUT + 1; c < 2**CMD_W; c++)
            rows.push_back(row(CMD_W'(c), VAR_W'(c * 4099), FANIN_W'(c), VAR_W'(c),
                               20'h3C3C3, CHK_ERROR));

        foreach (rows[k])
            send_gate(rows[k].g, rows[k].chk);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                tx_idle_pct = 86;
                rx_idle_pct = 21;
            end else if (ph == 2) begin
                tx_idle_pct  = 0;
                rx_idle_pct  = 0;
                hold_off_req = 1'b1;
            end
            for (int k = 0; k < RAND_PER_PHASE; k++)
                send_gate(random_gate(), CHK_MODEL);
        end

        @(negedge i_clk);
        push = 1'b0;
        while (clause_lits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
